/* rtl/hlrc_pkg.sv */
`timescale 1ns / 1ps

package hlrc_pkg;

  localparam int MAX_PARTS = 32;
  localparam int SIDE      = MAX_PARTS + 1;
  localparam int GRID      = SIDE * SIDE;
  localparam int LVL_DEPTH = GRID / 2 + 1;

  localparam int PART_W  = 40;
  localparam int SUM_W   = PART_W + $clog2(MAX_PARTS) + 1;
  localparam int CNT_W   = $clog2(MAX_PARTS + 1);
  localparam int PIDX_W  = $clog2(MAX_PARTS);
  localparam int CW      = $clog2(2 * SIDE + 2) + 1;
  localparam int HW      = 62;
  localparam int ACC_W   = 64;
  localparam int HADDR_W = $clog2(GRID);
  localparam int LVL_W   = $clog2(LVL_DEPTH);
  localparam int CCAP_W  = 62;
  localparam int NCAP_W  = 63;
  localparam int CFG_W   = 63;

  localparam logic [PART_W-1:0] PART_LIMIT = 40'd999999999999;
  localparam logic [CCAP_W-1:0] COUNT_CAP_RESET = 62'd1000000000000;
  localparam logic [NCAP_W-1:0] NODE_CAP_RESET  = 63'd200000000;

  localparam logic signed [ACC_W-1:0] LO_START = 64'shE000_0000_0000_0000;
  localparam logic signed [ACC_W-1:0] HI_START = 64'sh1FFF_FFFF_FFFF_FFFF;
  localparam logic signed [ACC_W-1:0] GUARD_LO = 64'shF000_0000_0000_0000;
  localparam logic signed [ACC_W-1:0] GUARD_HI = 64'sh0FFF_FFFF_FFFF_FFFF;

  localparam logic [1:0] ACT_LAM = 2'd0;
  localparam logic [1:0] ACT_MU  = 2'd1;
  localparam logic [1:0] ACT_NU  = 2'd2;
  localparam logic [1:0] ACT_NUL = 2'd3;

  localparam logic [1:0] STAT_OK  = 2'd0;
  localparam logic [1:0] STAT_CAP = 2'd1;
  localparam logic [1:0] STAT_BAD = 2'd2;

  localparam logic CFG_COUNT_CAP = 1'b0;
  localparam logic CFG_NODE_CAP  = 1'b1;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    logic [1:0]        action;
    logic [PART_W-1:0] part;
    logic              last;
  } item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [CCAP_W-1:0] count;
  } result_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_EVAL,
    S_BF_RD,
    S_BF_WR,
    S_CAND,
    S_RD,
    S_TK,
    S_APPLY,
    S_SW_END,
    S_NODE,
    S_NCHK,
    S_BOUND,
    S_ADD,
    S_PCHK,
    S_BT,
    S_BT_RD,
    S_BT_CHK,
    S_DONE
  } state_t;

endpackage

/* rtl/hive_lr_coefficient_counter_core.sv */
`timescale 1ns / 1ps

// Littlewood-Richardson coefficient by hive count. While busy is low one part is taken per
// cycle (start high); the transaction with last high closes the triple and busy stays high
// for the whole count. A malformed or size-mismatched triple, or one with no nonzero nu part,
// goes from evaluation straight to done. Else the hive boundary is filled (n = number of
// nonzero nu parts), then every boundary rhombus is checked (3(n+1)^2 candidates), then the
// depth-first search checks 27 rhombus candidates per search node and backtracks when a
// bound is empty or a hive is counted; each candidate reads its corner heights one at a time
// through the single read port of the hive height memory. The result appears on result for
// the one cycle that done is high and cannot be held off; busy falls after that cycle.
module hive_lr_coefficient_counter_core
  import hlrc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  item_t            item,
  output logic             done,
  output result_t          result,
  input  logic             cfg_wr,
  input  logic             cfg_idx,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam logic [1:0] RH_A = 2'd0;
  localparam logic [1:0] RH_B = 2'd1;
  localparam logic [1:0] RH_C = 2'd2;

  state_t state, state_next;

  logic [CCAP_W-1:0] count_cap;
  logic [NCAP_W-1:0] visit_cap;

  logic [CNT_W-1:0] cnt [3];
  logic [SUM_W-1:0] sum [3];
  logic [PART_W-1:0] last_p [3];
  logic [2:0] zseen;
  logic malformed;

  logic [SUM_W-1:0] lam_mem [MAX_PARTS];
  logic [SUM_W-1:0] mu_mem [MAX_PARTS];
  logic [SUM_W-1:0] nu_mem [MAX_PARTS];
  logic [SUM_W-1:0] lam_rd, mu_rd, nu_rd;
  logic [PIDX_W-1:0] st_raddr;

  logic [HW-1:0] hive_mem [GRID];
  logic [HW-1:0] hive_rd;
  logic hive_we;
  logic [HADDR_W-1:0] hive_waddr, hive_raddr;
  logic [HW-1:0] hive_wdata;

  logic [2*HW-1:0] lvl_mem [LVL_DEPTH];
  logic [2*HW-1:0] lvl_rd, lvl_wdata;
  logic lvl_we;

  logic [1:0] res_status;
  logic [CCAP_W-1:0] res_count;

  logic [1:0] bsel;
  logic [CNT_W-1:0] bi;
  logic mode;
  logic [CNT_W-1:0] ccx, ccy;
  logic [1:0] ct, ridx;
  logic signed [ACC_W-1:0] acc, lo, hi;
  logic fail;
  coord_t vx, vy;
  logic [LVL_W-1:0] k;
  logic [ACC_W-1:0] path, node;

  // load side
  logic acc_in, act_ok, too_big, is_zero, bad_order, take, mark_bad, mark_zero;
  logic [1:0] asel;
  logic [SUM_W-1:0] pre;

  assign acc_in = start && (state == S_IDLE);
  assign act_ok = item.action != ACT_NUL;
  assign asel = act_ok ? item.action : ACT_LAM;
  assign too_big = item.part > PART_LIMIT;
  assign is_zero = item.part == '0;
  assign bad_order = zseen[asel] || ((cnt[asel] != '0) && (item.part > last_p[asel]))
                     || (cnt[asel] >= CNT_W'(MAX_PARTS));
  assign take = acc_in && act_ok && !too_big && !is_zero && !bad_order;
  assign mark_bad = acc_in && act_ok && (too_big || (!is_zero && bad_order));
  assign mark_zero = acc_in && act_ok && !too_big && is_zero;
  assign pre = sum[asel] + SUM_W'(item.part);

  function automatic logic [HADDR_W-1:0] haddr(coord_t x, coord_t y);
    logic [HADDR_W-1:0] xs, ys;
    xs = HADDR_W'(unsigned'(x));
    ys = HADDR_W'(unsigned'(y));
    return HADDR_W'(xs * HADDR_W'(SIDE) + ys);
  endfunction

  function automatic logic inner(coord_t x, coord_t y, coord_t nv);
    return (y >= 1) && (y <= nv - 2) && (x >= 1) && (x + y <= nv - 1);
  endfunction

  function automatic logic later(coord_t ax, coord_t ay, coord_t bx, coord_t by);
    return (ay > by) || ((ay == by) && (ax > bx));
  endfunction

  // rhombus candidate evaluation
  coord_t nn, bx, by, bix;
  coord_t ex [4];
  coord_t ey [4];
  logic cond, c_valid, has_v, blocked, any_inner, c_use, c_last;
  logic [1:0] vpos;
  logic [CNT_W-1:0] c_lim;

  assign nn = coord_t'(CW'(cnt[2]));
  assign bix = coord_t'(CW'(bi));

  always_comb begin
    if (mode) begin
      bx = vx + coord_t'(CW'(ccx)) - coord_t'(1);
      by = vy + coord_t'(CW'(ccy)) - coord_t'(1);
    end else begin
      bx = coord_t'(CW'(ccx));
      by = coord_t'(CW'(ccy));
    end
    case (ct)
      RH_A: begin
        ex[0] = bx + coord_t'(1); ey[0] = by;
        ex[1] = bx;               ey[1] = by + coord_t'(1);
        ex[2] = bx;               ey[2] = by;
        ex[3] = bx + coord_t'(1); ey[3] = by + coord_t'(1);
        cond = (bx + by <= nn - 2);
      end
      RH_B: begin
        ex[0] = bx;               ey[0] = by;
        ex[1] = bx + coord_t'(1); ey[1] = by;
        ex[2] = bx;               ey[2] = by + coord_t'(1);
        ex[3] = bx + coord_t'(1); ey[3] = by - coord_t'(1);
        cond = (by >= 1) && (bx + by <= nn - 1);
      end
      RH_C: begin
        ex[0] = bx;               ey[0] = by;
        ex[1] = bx;               ey[1] = by + coord_t'(1);
        ex[2] = bx + coord_t'(1); ey[2] = by;
        ex[3] = bx - coord_t'(1); ey[3] = by + coord_t'(1);
        cond = (bx >= 1) && (bx + by <= nn - 1);
      end
      default: begin
        ex[0] = bx; ey[0] = by;
        ex[1] = bx; ey[1] = by;
        ex[2] = bx; ey[2] = by;
        ex[3] = bx; ey[3] = by;
        cond = 1'b0;
      end
    endcase
    c_valid = (bx >= 0) && (by >= 0) && cond;
    has_v = 1'b0;
    blocked = 1'b0;
    any_inner = 1'b0;
    vpos = '0;
    for (int i = 0; i < 4; i++) begin
      if ((ex[i] == vx) && (ey[i] == vy)) begin
        has_v = 1'b1;
        vpos = 2'(i);
      end
      if (inner(ex[i], ey[i], nn)) begin
        any_inner = 1'b1;
        if (later(ex[i], ey[i], vx, vy)) blocked = 1'b1;
      end
    end
    c_use = c_valid && (mode ? (has_v && !blocked) : !any_inner);
    c_lim = mode ? CNT_W'(2) : cnt[2];
    c_last = (ccx == c_lim) && (ccy == c_lim) && (ct == RH_C);
  end

  // search decisions
  logic signed [ACC_W-1:0] hv, neg_acc;
  logic signed [HW-1:0] lvl_val, lvl_upp, lvl_inc;
  logic rd_skip, rd_end, bnd_ok, guard_hit, v_last, bt_inc, sums_bad;
  coord_t nx, ny, px, py;

  assign hv = ACC_W'(signed'(hive_rd));
  assign neg_acc = -acc;
  assign lvl_val = signed'(lvl_rd[2*HW-1:HW]);
  assign lvl_upp = signed'(lvl_rd[HW-1:0]);
  assign lvl_inc = lvl_val + HW'(1);
  assign rd_skip = mode && (ridx == vpos);
  assign rd_end = ridx == 2'd3;
  assign bnd_ok = lo <= hi;
  assign guard_hit = (lo <= GUARD_LO) || (hi >= GUARD_HI);
  assign v_last = (vx == coord_t'(1)) && (vy == nn - coord_t'(2));
  assign bt_inc = lvl_val < lvl_upp;
  assign sums_bad = ((SUM_W + 1)'(sum[0]) + (SUM_W + 1)'(sum[1]) != (SUM_W + 1)'(sum[2]))
                    || (cnt[0] > cnt[2]) || (cnt[1] > cnt[2]);

  always_comb begin
    if (vx + vy + coord_t'(1) <= nn - coord_t'(1)) begin
      nx = vx + coord_t'(1);
      ny = vy;
    end else begin
      nx = coord_t'(1);
      ny = vy + coord_t'(1);
    end
    if (vx > coord_t'(1)) begin
      px = vx - coord_t'(1);
      py = vy;
    end else begin
      px = nn - vy;
      py = vy - coord_t'(1);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (acc_in && item.last) state_next = S_EVAL;
      S_EVAL: begin
        if (malformed || sums_bad || (cnt[2] == '0)) state_next = S_DONE;
        else state_next = S_BF_RD;
      end
      S_BF_RD:  state_next = S_BF_WR;
      S_BF_WR: begin
        if ((bi == cnt[2]) && (bsel == ACT_NU)) state_next = S_CAND;
        else state_next = S_BF_RD;
      end
      S_CAND: begin
        if (c_use) state_next = S_RD;
        else if (c_last) state_next = mode ? S_BOUND : S_SW_END;
      end
      S_RD: begin
        if (!rd_skip) state_next = S_TK;
        else if (rd_end) state_next = S_APPLY;
      end
      S_TK:     state_next = rd_end ? S_APPLY : S_RD;
      S_APPLY: begin
        if (c_last) state_next = mode ? S_BOUND : S_SW_END;
        else state_next = S_CAND;
      end
      S_SW_END: state_next = (fail || (cnt[2] < CNT_W'(3))) ? S_DONE : S_NODE;
      S_NODE:   state_next = S_NCHK;
      S_NCHK:   state_next = (node > ACC_W'(visit_cap)) ? S_DONE : S_CAND;
      S_BOUND: begin
        if (!bnd_ok) state_next = S_BT;
        else if (guard_hit) state_next = S_DONE;
        else if (v_last) state_next = S_ADD;
        else state_next = S_NODE;
      end
      S_ADD:    state_next = S_PCHK;
      S_PCHK:   state_next = (path > ACC_W'(count_cap)) ? S_DONE : S_BT;
      S_BT:     state_next = (k == '0) ? S_DONE : S_BT_RD;
      S_BT_RD:  state_next = S_BT_CHK;
      S_BT_CHK: state_next = bt_inc ? S_NODE : S_BT;
      S_DONE:   state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // outputs and memory strobes
  always_comb begin
    busy = state != S_IDLE;
    done = state == S_DONE;
    result.status = res_status;
    result.count = res_count;
    hive_we = 1'b0;
    hive_waddr = haddr(vx, vy);
    hive_wdata = lo[HW-1:0];
    lvl_we = 1'b0;
    lvl_wdata = {lo[HW-1:0], hi[HW-1:0]};
    st_raddr = PIDX_W'(bi - CNT_W'(1));
    hive_raddr = haddr(ex[ridx], ey[ridx]);
    case (state)
      S_BF_WR: begin
        hive_we = 1'b1;
        case (bsel)
          ACT_LAM: begin
            hive_waddr = haddr(coord_t'(0), bix);
            if (bi == '0) hive_wdata = '0;
            else if (bi <= cnt[0]) hive_wdata = HW'(lam_rd);
            else hive_wdata = HW'(sum[0]);
          end
          ACT_MU: begin
            hive_waddr = haddr(bix, nn - bix);
            if (bi == '0) hive_wdata = HW'(sum[0]);
            else if (bi <= cnt[1]) hive_wdata = HW'(sum[0]) + HW'(mu_rd);
            else hive_wdata = HW'(sum[0]) + HW'(sum[1]);
          end
          default: begin
            hive_waddr = haddr(bix, coord_t'(0));
            hive_wdata = (bi == '0) ? '0 : HW'(nu_rd);
          end
        endcase
      end
      S_BOUND: begin
        hive_we = bnd_ok && !guard_hit && !v_last;
        lvl_we = hive_we;
      end
      S_BT_CHK: begin
        hive_we = bt_inc;
        hive_wdata = lvl_inc;
        lvl_we = bt_inc;
        lvl_wdata = {lvl_inc, lvl_upp};
      end
      default: begin
        hive_we = 1'b0;
      end
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (take && (asel == ACT_LAM)) lam_mem[cnt[0][PIDX_W-1:0]] <= pre;
    if (take && (asel == ACT_MU)) mu_mem[cnt[1][PIDX_W-1:0]] <= pre;
    if (take && (asel == ACT_NU)) nu_mem[cnt[2][PIDX_W-1:0]] <= pre;
    lam_rd <= lam_mem[st_raddr];
    mu_rd <= mu_mem[st_raddr];
    nu_rd <= nu_mem[st_raddr];
  end

  always_ff @(posedge clk) begin
    if (hive_we) hive_mem[hive_waddr] <= hive_wdata;
    hive_rd <= hive_mem[hive_raddr];
  end

  always_ff @(posedge clk) begin
    if (lvl_we) lvl_mem[k] <= lvl_wdata;
    lvl_rd <= lvl_mem[k];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count_cap <= COUNT_CAP_RESET;
      visit_cap <= NODE_CAP_RESET;
      for (int i = 0; i < 3; i++) begin
        cnt[i] <= '0;
        sum[i] <= '0;
      end
      zseen <= '0;
      malformed <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr) begin
        case (cfg_idx)
          CFG_COUNT_CAP: count_cap <= cfg_data[CCAP_W-1:0];
          CFG_NODE_CAP:  visit_cap <= cfg_data[NCAP_W-1:0];
          default:       count_cap <= count_cap;
        endcase
      end
      if (take) begin
        cnt[asel] <= cnt[asel] + CNT_W'(1);
        sum[asel] <= pre;
      end
      if (mark_zero) zseen[asel] <= 1'b1;
      if (mark_bad) malformed <= 1'b1;
      if (state == S_DONE) begin
        for (int i = 0; i < 3; i++) begin
          cnt[i] <= '0;
          sum[i] <= '0;
        end
        zseen <= '0;
        malformed <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (take) last_p[asel] <= item.part;
    case (state)
      S_EVAL: begin
        res_count <= '0;
        res_status <= malformed ? STAT_BAD : STAT_OK;
        if (!malformed && !sums_bad && (cnt[2] == '0)) res_count <= CCAP_W'(1);
        bsel <= ACT_LAM;
        bi <= '0;
      end
      S_BF_WR: begin
        if (bi == cnt[2]) begin
          bi <= '0;
          bsel <= bsel + 2'd1;
        end else begin
          bi <= bi + CNT_W'(1);
        end
        mode <= 1'b0;
        ccx <= '0;
        ccy <= '0;
        ct <= RH_A;
        fail <= 1'b0;
        vx <= coord_t'(0);
        vy <= coord_t'(0);
      end
      S_CAND: begin
        ridx <= '0;
        acc <= '0;
        if (!c_use) begin
          if (ct == RH_C) begin
            ct <= RH_A;
            if (ccy == c_lim) begin
              ccy <= '0;
              ccx <= ccx + CNT_W'(1);
            end else begin
              ccy <= ccy + CNT_W'(1);
            end
          end else begin
            ct <= ct + 2'd1;
          end
        end
      end
      S_RD: begin
        if (rd_skip && !rd_end) ridx <= ridx + 2'd1;
      end
      S_TK: begin
        acc <= ridx[1] ? acc - hv : acc + hv;
        if (!rd_end) ridx <= ridx + 2'd1;
      end
      S_APPLY: begin
        if (!mode) begin
          if (acc < 0) fail <= 1'b1;
        end else if (!vpos[1]) begin
          if (neg_acc > lo) lo <= neg_acc;
        end else begin
          if (acc < hi) hi <= acc;
        end
        if (ct == RH_C) begin
          ct <= RH_A;
          if (ccy == c_lim) begin
            ccy <= '0;
            ccx <= ccx + CNT_W'(1);
          end else begin
            ccy <= ccy + CNT_W'(1);
          end
        end else begin
          ct <= ct + 2'd1;
        end
      end
      S_SW_END: begin
        res_status <= STAT_OK;
        res_count <= fail ? '0 : CCAP_W'(1);
        mode <= 1'b1;
        vx <= coord_t'(1);
        vy <= coord_t'(1);
        k <= '0;
        path <= '0;
        node <= '0;
      end
      S_NODE: begin
        node <= node + ACC_W'(1);
      end
      S_NCHK: begin
        res_status <= STAT_CAP;
        res_count <= '0;
        lo <= LO_START;
        hi <= HI_START;
        ccx <= '0;
        ccy <= '0;
        ct <= RH_A;
      end
      S_BOUND: begin
        res_status <= STAT_CAP;
        res_count <= '0;
        if (bnd_ok && !guard_hit && !v_last) begin
          k <= k + LVL_W'(1);
          vx <= nx;
          vy <= ny;
        end
      end
      S_ADD: begin
        path <= path + ACC_W'(hi - lo) + ACC_W'(1);
      end
      S_PCHK: begin
        res_status <= STAT_CAP;
        res_count <= '0;
      end
      S_BT: begin
        res_status <= STAT_OK;
        res_count <= path[CCAP_W-1:0];
        if (k != '0) begin
          k <= k - LVL_W'(1);
          vx <= px;
          vy <= py;
        end
      end
      S_BT_CHK: begin
        if (bt_inc) begin
          k <= k + LVL_W'(1);
          vx <= nx;
          vy <= ny;
        end
      end
      default: begin
        mode <= mode;
      end
    endcase
  end

endmodule
